### hw/rtl/olid_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package olid_pkg;

  // Field widths fixed by the command and result formats
  localparam int unsigned OPCODE_W = 2;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;

  // Opcodes
  localparam logic [OPCODE_W-1:0] OP_FRONT  = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_BACK   = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_DELETE = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

  typedef struct packed {
    logic [OPCODE_W-1:0]       opcode;
    logic signed [VALUE_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
  } out_item_t;

  // Decoded command kind, as handed from the front to the back
  typedef enum logic [1:0] {
    CMD_FRONT,
    CMD_BACK,
    CMD_DELETE,
    CMD_NOP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t           kind;
    logic [VALUE_W-1:0]  value;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_SHIFT
  } back_state_t;

endpackage : olid_pkg

`default_nettype wire

### hw/rtl/ordered_list_insert_delete.sv
// Channel   Direction  Payload     Transfer when
// in_       input      in_item_t   in_valid && in_ready
// out_      output     out_item_t  out_valid && out_ready
//
// Insert at front, append, full refusal and unused opcodes finish in the idle state; a delete
// on a non-empty list scans and, on a hit, closes the gap, with one RAM read per entry scanned
// and one per entry moved through the registered-read entry RAM.
// A command passes a queue slot and then the result register before out_valid rises.
// rst_n is synchronous, active low; it empties the list and the queue.
// The queue holds two commands; the back starts one only once the result register is free.
`timescale 1ns / 1ps
`default_nettype none

module ordered_list_insert_delete
  import olid_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_ready,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  wire        out_ready,
  output out_item_t  out_data
);

  // Decoded commands queued between front and back
  logic q_valid;
  logic q_ready;
  cmd_t q_cmd;

  // Front: accept the transfer, decode the opcode, hold it in the queue
  olid_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_cmd    (q_cmd)
  );

  // Back: circular buffer in RAM; scan and close the gap on delete,
  // register the result until the transfer on the output side
  olid_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_cmd     (q_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule : ordered_list_insert_delete

`default_nettype wire

### hw/rtl/olid_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module olid_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire                     clk,
  input  wire                     we,
  input  wire [$clog2(DEPTH)-1:0] waddr,
  input  wire [WIDTH-1:0]         wdata,
  input  wire                     re,
  input  wire [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]        rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule : olid_ram

`default_nettype wire

### hw/rtl/olid_front.sv
`timescale 1ns / 1ps
`default_nettype none

module olid_front
  import olid_pkg::*;
(
  input  wire       clk,
  input  wire       rst_n,
  input  wire       in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      q_valid,
  input  wire       q_ready,
  output cmd_t      q_cmd
);

  // Two-entry command queue
  cmd_t       slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] fill_r, fill_nxt;
  cmd_t       cmd_dec;
  logic       push, pop;

  // Classify the opcode; unused codes become a no-op
  always_comb begin
    cmd_dec.value = in_data.value;
    unique case (in_data.opcode)
      OP_FRONT:  cmd_dec.kind = CMD_FRONT;
      OP_BACK:   cmd_dec.kind = CMD_BACK;
      OP_DELETE: cmd_dec.kind = CMD_DELETE;
      default:   cmd_dec.kind = CMD_NOP;
    endcase
  end

  assign in_ready = (fill_r != 2'd2);
  assign q_valid  = (fill_r != 2'd0);
  assign q_cmd    = slot_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    fill_nxt   = fill_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= cmd_dec;
    end
  end

endmodule : olid_front

`default_nettype wire

### hw/rtl/olid_back.sv
`timescale 1ns / 1ps
`default_nettype none

module olid_back
  import olid_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        q_valid,
  output logic       q_ready,
  input  cmd_t       q_cmd,
  output logic       out_valid,
  input  wire        out_ready,
  output out_item_t  out_data
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(CAPACITY - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(CAPACITY);

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == LAST_PTR) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
    return (p == '0) ? LAST_PTR : p - 1'b1;
  endfunction

  back_state_t        state_r, state_nxt;
  logic [AW-1:0]      head_r, head_nxt;
  logic [AW-1:0]      tail_r, tail_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [VALUE_W-1:0] key_r, key_nxt;
  logic [AW-1:0]      iss_ptr_r, iss_ptr_nxt;
  logic [CW-1:0]      iss_idx_r, iss_idx_nxt;
  logic               chk_vld_r, chk_vld_nxt;
  logic [AW-1:0]      chk_ptr_r, chk_ptr_nxt;
  logic [CW-1:0]      chk_idx_r, chk_idx_nxt;
  logic [AW-1:0]      sh_rd_ptr_r, sh_rd_ptr_nxt;
  logic [AW-1:0]      sh_wr_ptr_r, sh_wr_ptr_nxt;
  logic [CW-1:0]      sh_left_r, sh_left_nxt;
  logic               sh_wv_r, sh_wv_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r, out_data_nxt;

  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [VALUE_W-1:0] ram_wdata, ram_rdata;

  logic               start, hit, miss_last, shift_done, full;
  logic               res_load;
  logic [STATUS_W-1:0] res_status;

  olid_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign q_ready    = (state_r == BK_IDLE) && !out_valid_r;
  assign start      = q_valid && q_ready;
  assign full       = (count_r == FULL_CNT);
  assign hit        = chk_vld_r && (ram_rdata == key_r);
  assign miss_last  = chk_vld_r && !hit && (chk_idx_r == count_r - 1'b1);
  assign shift_done = (sh_left_r == '0) && !sh_wv_r;
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (start && (q_cmd.kind == CMD_DELETE) && (count_r != '0)) begin
          state_nxt = BK_SCAN;
        end
      end
      BK_SCAN: begin
        if (hit) begin
          state_nxt = BK_SHIFT;
        end else if (miss_last) begin
          state_nxt = BK_IDLE;
        end
      end
      BK_SHIFT: begin
        if (shift_done) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    key_nxt       = key_r;
    iss_ptr_nxt   = iss_ptr_r;
    iss_idx_nxt   = iss_idx_r;
    chk_vld_nxt   = chk_vld_r;
    chk_ptr_nxt   = chk_ptr_r;
    chk_idx_nxt   = chk_idx_r;
    sh_rd_ptr_nxt = sh_rd_ptr_r;
    sh_wr_ptr_nxt = sh_wr_ptr_r;
    sh_left_nxt   = sh_left_r;
    sh_wv_nxt     = sh_wv_r;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = '0;
    ram_re        = 1'b0;
    ram_raddr     = '0;
    res_load      = 1'b0;
    res_status    = ST_OK;

    unique case (state_r)
      BK_IDLE: begin
        if (start) begin
          unique case (q_cmd.kind)
            CMD_FRONT: begin
              res_load = 1'b1;
              if (full) begin
                res_status = ST_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = ptr_dec(head_r);
                ram_wdata = q_cmd.value;
                head_nxt  = ptr_dec(head_r);
                count_nxt = count_r + 1'b1;
              end
            end
            CMD_BACK: begin
              res_load = 1'b1;
              if (full) begin
                res_status = ST_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = tail_r;
                ram_wdata = q_cmd.value;
                tail_nxt  = ptr_inc(tail_r);
                count_nxt = count_r + 1'b1;
              end
            end
            CMD_DELETE: begin
              if (count_r == '0) begin
                res_load   = 1'b1;
                res_status = ST_NOT_FOUND;
              end else begin
                key_nxt     = q_cmd.value;
                iss_ptr_nxt = head_r;
                iss_idx_nxt = '0;
                chk_vld_nxt = 1'b0;
              end
            end
            CMD_NOP: begin
              res_load = 1'b1;
            end
            default: begin
              res_load = 1'b1;
            end
          endcase
        end
      end

      BK_SCAN: begin
        if (hit) begin
          sh_rd_ptr_nxt = ptr_inc(chk_ptr_r);
          sh_wr_ptr_nxt = chk_ptr_r;
          sh_left_nxt   = count_r - 1'b1 - chk_idx_r;
          sh_wv_nxt     = 1'b0;
          chk_vld_nxt   = 1'b0;
        end else if (miss_last) begin
          res_load    = 1'b1;
          res_status  = ST_NOT_FOUND;
          chk_vld_nxt = 1'b0;
        end else if (iss_idx_r < count_r) begin
          ram_re      = 1'b1;
          ram_raddr   = iss_ptr_r;
          iss_ptr_nxt = ptr_inc(iss_ptr_r);
          iss_idx_nxt = iss_idx_r + 1'b1;
          chk_vld_nxt = 1'b1;
          chk_ptr_nxt = iss_ptr_r;
          chk_idx_nxt = iss_idx_r;
        end else begin
          chk_vld_nxt = 1'b0;
        end
      end

      BK_SHIFT: begin
        if (sh_wv_r) begin
          ram_we        = 1'b1;
          ram_waddr     = sh_wr_ptr_r;
          ram_wdata     = ram_rdata;
          sh_wr_ptr_nxt = ptr_inc(sh_wr_ptr_r);
        end
        if (sh_left_r != '0) begin
          ram_re        = 1'b1;
          ram_raddr     = sh_rd_ptr_r;
          sh_rd_ptr_nxt = ptr_inc(sh_rd_ptr_r);
          sh_left_nxt   = sh_left_r - 1'b1;
          sh_wv_nxt     = 1'b1;
        end else begin
          sh_wv_nxt = 1'b0;
        end
        if (shift_done) begin
          res_load  = 1'b1;
          count_nxt = count_r - 1'b1;
          tail_nxt  = ptr_dec(tail_r);
        end
      end

      default: begin
        res_load = 1'b0;
      end
    endcase

    out_data_nxt        = out_data_r;
    out_data_nxt.status = res_load ? res_status : out_data_r.status;
    out_data_nxt.count  = res_load ? COUNT_W'(count_nxt) : out_data_r.count;
    out_valid_nxt       = res_load || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      chk_vld_r   <= 1'b0;
      sh_wv_r     <= 1'b0;
      sh_left_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      chk_vld_r   <= chk_vld_nxt;
      sh_wv_r     <= sh_wv_nxt;
      sh_left_r   <= sh_left_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r       <= key_nxt;
    iss_ptr_r   <= iss_ptr_nxt;
    iss_idx_r   <= iss_idx_nxt;
    chk_ptr_r   <= chk_ptr_nxt;
    chk_idx_r   <= chk_idx_nxt;
    sh_rd_ptr_r <= sh_rd_ptr_nxt;
    sh_wr_ptr_r <= sh_wr_ptr_nxt;
    out_data_r  <= out_data_nxt;
  end

endmodule : olid_back

`default_nettype wire

### hw/rtl/olid_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module olid_checker
  import olid_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input wire       clk,
  input wire       rst_n,
  input wire       in_valid,
  input wire       in_ready,
  input in_item_t  in_data,
  input wire       out_valid,
  input wire       out_ready,
  input out_item_t out_data
);

  // A waiting command holds until its transfer
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("command changed while stalled");

  // A waiting result holds until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // No result is left over from before reset
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A refused insert reports a full list
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_FULL) |->
      out_data.count == COUNT_W'(CAPACITY))
    else $error("full status with count below capacity");

  // Only defined status codes come out, and count stays within capacity
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status == ST_OK || out_data.status == ST_NOT_FOUND ||
                   out_data.status == ST_FULL) &&
                  (CAPACITY > 31 || out_data.count <= CAPACITY))
    else $error("bad status or count");

endmodule : olid_checker

bind ordered_list_insert_delete olid_checker #(.CAPACITY(CAPACITY)) u_olid_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

### tb/ordered_list_checker.sv
`timescale 1ns / 1ps

module ordered_list_checker
  import olid_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_valid,
  input  wire              in_ready,
  input  in_item_t         in_data,
  input  wire              out_valid,
  input  wire              out_ready,
  input  out_item_t        out_data,
  output int unsigned      pending_results,
  output int unsigned      fail_count
);

  localparam int unsigned REPORT_LIMIT = 10;

  // Shadow copy of the list: entries at positions below list_len are live
  logic [VALUE_W-1:0] list_vals [CAPACITY];
  int unsigned        list_len = 0;

  out_item_t   expected_results [$];
  out_item_t   oldest_expected;
  int unsigned failures = 0;
  int unsigned result_index = 0;

  initial begin
    pending_results = 0;
    fail_count = 0;
  end

  // Apply one command to the shadow list and return the status and count it yields
  function automatic out_item_t apply_command(input in_item_t cmd);
    out_item_t   res;
    int unsigned pos;
    bit          hit;
    res.status = ST_OK;
    case (cmd.opcode)
      OP_FRONT, OP_BACK: begin
        if (list_len >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          if (cmd.opcode == OP_FRONT) begin
            for (pos = list_len; pos > 0; pos--) list_vals[pos] = list_vals[pos - 1];
            list_vals[0] = cmd.value;
          end else begin
            list_vals[list_len] = cmd.value;
          end
          list_len++;
        end
      end
      OP_DELETE: begin
        hit = 1'b0;
        for (pos = 0; pos < list_len; pos++) begin
          if (list_vals[pos] == cmd.value) begin
            hit = 1'b1;
            break;
          end
        end
        if (hit) begin
          // close the gap behind the removed entry
          for (; pos + 1 < list_len; pos++) list_vals[pos] = list_vals[pos + 1];
          list_len--;
        end else begin
          res.status = ST_NOT_FOUND;
        end
      end
      default: ;  // unused opcode leaves the list alone
    endcase
    res.count = COUNT_W'(list_len);
    return res;
  endfunction

  task automatic note_failure(input string what);
    failures++;
    if (failures <= REPORT_LIMIT) $display("[%0t] result %0d: %s", $time, result_index, what);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      list_len = 0;
      expected_results.delete();
    end else begin
      // compare first: a result can never belong to a command taken at this same edge
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          note_failure($sformatf("unexpected result status %0d count %0d",
                                 out_data.status, out_data.count));
        end else begin
          oldest_expected = expected_results.pop_front();
          if (out_data.status !== oldest_expected.status ||
              out_data.count !== oldest_expected.count) begin
            note_failure($sformatf("mismatch: status exp %0d got %0d, count exp %0d got %0d",
                                   oldest_expected.status, out_data.status,
                                   oldest_expected.count, out_data.count));
          end
        end
        result_index++;
      end
      if (in_valid && in_ready) expected_results.push_back(apply_command(in_data));
    end
    pending_results <= expected_results.size();
    fail_count      <= failures;
  end

endmodule : ordered_list_checker

### tb/tb_ordered_list_insert_delete.sv
`timescale 1ns / 1ps

module tb_ordered_list_insert_delete;
  import olid_pkg::*;

  localparam int unsigned CAPACITY     = 16;
  localparam int unsigned RANDOM_ITEMS = 850;
  // At the end, settle for longer than the longest delete takes in the back end
  localparam int unsigned SETTLE_CYCLES = CAPACITY + 8;
  localparam int unsigned CYCLE_LIMIT   = 400000;

  // The package names three opcodes; the fourth encoding is unused and must be ignored
  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    RDY_ALWAYS,
    RDY_PATTERN,
    RDY_SPARSE
  } ready_mode_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  int unsigned pending_results;
  int unsigned fail_count;
  int unsigned burst_left = 0;
  int unsigned cycle_count = 0;

  ordered_list_insert_delete #(
    .CAPACITY (CAPACITY)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  ordered_list_checker #(
    .CAPACITY (CAPACITY)
  ) checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data),
    .pending_results (pending_results),
    .fail_count      (fail_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Guard against a hung handshake: end the run as a failure once the limit is hit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver: pick a stall mode for a random stretch. One mode never stalls, one
  // rotates a random 8-bit pattern, one accepts only about a quarter of the time.
  ready_mode_t ready_mode = RDY_ALWAYS;
  int unsigned mode_left = 0;
  logic [7:0]  ready_pat = 8'hFF;

  always @(posedge clk) begin
    if (mode_left == 0) begin
      ready_mode <= ready_mode_t'($urandom_range(2, 0));
      mode_left  <= $urandom_range(200, 20);
      ready_pat  <= 8'($urandom_range(255, 1));
    end else begin
      mode_left <= mode_left - 1;
      ready_pat <= {ready_pat[6:0], ready_pat[7]};
    end
    case (ready_mode)
      RDY_ALWAYS:  out_ready <= 1'b1;
      RDY_PATTERN: out_ready <= ready_pat[0];
      default:     out_ready <= ($urandom_range(3, 0) == 0);
    endcase
  end

  // Present one command and hold it until the transfer. Within a burst keep valid
  // high into the next command; otherwise drop valid and idle for a random gap.
  task automatic send_command(input logic [OPCODE_W-1:0] op, input logic [VALUE_W-1:0] val);
    in_item_t cmd;
    cmd.opcode = op;
    cmd.value  = val;
    in_valid <= 1'b1;
    in_data  <= cmd;
    do @(posedge clk); while (!in_ready);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(12, 1)) @(posedge clk);
      burst_left = $urandom_range(30, 0);
    end
  endtask

  // Hold the sender off until every result in flight has come back. Sample the
  // checker's count at the falling edge, then realign to the rising edge.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_results != 0);
    @(posedge clk);
  endtask

  // Bias values toward a small set so that deletes hit and duplicates pile up,
  // mixed with the extremes and fully random words.
  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(9, 0))
      0:          return 32'h8000_0000;
      1:          return 32'h7FFF_FFFF;
      2:          return 32'hFFFF_FFFF;
      3, 4, 5, 6: return VALUE_W'($urandom_range(7, 0));
      default:    return $urandom;
    endcase
  endfunction

  initial begin
    logic [VALUE_W-1:0] fill_vals [4];
    logic [OPCODE_W-1:0] op;
    int unsigned roll;
    int unsigned phase_left;
    bit filling;

    fill_vals[0] = 32'h0000_0000;
    fill_vals[1] = 32'hFFFF_FFFF;
    fill_vals[2] = 32'h5555_5555;
    fill_vals[3] = 32'hAAAA_AAAA;
    phase_left = 0;
    filling = 1'b0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty-list cases first
    send_command(OP_DELETE, 32'd5);             // delete from an empty list
    send_command(OP_UNUSED, 32'hFFFF_FFFF);     // unused opcode on an empty list
    send_command(OP_FRONT,  32'h8000_0000);
    send_command(OP_BACK,   32'h7FFF_FFFF);
    send_command(OP_DELETE, 32'h8000_0001);     // one bit off a held value: no match
    send_command(OP_DELETE, 32'h7FFF_FFFF);     // match at the back
    // Fill to capacity with repeating values, alternating front and back
    for (int k = 0; k < CAPACITY - 1; k++) begin
      send_command(k[0] ? OP_BACK : OP_FRONT, fill_vals[k % 4]);
    end
    send_command(OP_FRONT,  32'd1);             // refused: list full
    send_command(OP_BACK,   32'd2);             // refused: list full
    send_command(OP_UNUSED, 32'd0);             // unused opcode on a full list
    send_command(OP_DELETE, 32'h8000_0000);     // match deep in the list
    send_command(OP_DELETE, 32'hFFFF_FFFF);     // first of several duplicates
    wait_for_drain();

    // Random: alternate filling and draining stretches so the list swings
    // between empty and full; sprinkle in the unused opcode.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (phase_left == 0) begin
        filling = !filling;
        phase_left = $urandom_range(60, 15);
      end
      phase_left--;
      roll = $urandom_range(99, 0);
      if (roll < 4) begin
        op = OP_UNUSED;
      end else if (filling ? (roll < 80) : (roll >= 75)) begin
        op = $urandom_range(1, 0) ? OP_BACK : OP_FRONT;
      end else begin
        op = OP_DELETE;
      end
      send_command(op, pick_value());
      if (n % 200 == 199) wait_for_drain();
    end

    // Let everything come back, then watch a little longer for stray results
    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_results == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule : tb_ordered_list_insert_delete

### sim.f
hw/rtl/olid_pkg.sv
hw/rtl/olid_ram.sv
hw/rtl/olid_front.sv
hw/rtl/olid_back.sv
hw/rtl/ordered_list_insert_delete.sv
hw/rtl/olid_checker.sv
tb/ordered_list_checker.sv
tb/tb_ordered_list_insert_delete.sv
